FILE: sv/iorw_pkg.sv
package iorw_pkg;

   typedef enum logic [1:0] {
      KIND_ACK     = 2'd0,
      KIND_DELIVER = 2'd1,
      KIND_RELEASE = 2'd2
   } kind_type;

   // one result word as it leaves the sequencer
   typedef struct packed {
      kind_type    kind;
      logic [31:0] seq_num;
      logic [15:0] tag;
      logic        part;
      logic        gend;
   } result_type;

endpackage

FILE: sv/iorw_ram.sv
module iorw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: sv/iorw_outq.sv
module iorw_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  iorw_pkg::result_type  res,
   input  logic                  finish,
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_result_kind,
   output logic [31:0]           rsp_result_sequence,
   output logic [15:0]           rsp_result_tag,
   output logic                  rsp_part_of_group,
   output logic                  rsp_group_end,
   output logic                  rsp_is_last
);
   import iorw_pkg::*;

   // one word held back until we know whether another follows
   result_type pend_ff, pend_in;
   logic       pend_valid_ff, pend_valid_in;
   result_type out_ff, out_in;
   logic       strobe_ff, strobe_in;
   logic       last_ff, last_in;

   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      strobe_in     = 1'b0;
      last_in       = 1'b0;
      if (finish) begin
         out_in        = pend_ff;
         strobe_in     = pend_valid_ff;
         last_in       = 1'b1;
         pend_valid_in = 1'b0;
      end else if (push) begin
         out_in        = pend_ff;
         strobe_in     = pend_valid_ff;
         pend_in       = res;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
      if (reset) begin
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
         last_ff       <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         strobe_ff     <= strobe_in;
         last_ff       <= last_in;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_result_kind     = out_ff.kind;
   assign rsp_result_sequence = out_ff.seq_num;
   assign rsp_result_tag      = out_ff.tag;
   assign rsp_part_of_group   = out_ff.part;
   assign rsp_group_end       = out_ff.gend;
   assign rsp_is_last         = last_ff;
endmodule

FILE: sv/inorder_receive_window.sv
// in-order receive window for one connection. a packet is taken when start is high
// and busy is low; busy then falls as the last word that packet causes shows on the
// rsp_ ports. results come one per strobe cycle on the rsp_ ports and cannot be
// held off; rsp_is_last marks the final word of a packet. the sequencer walks the
// window one slot at a time through a single registered-read slot memory; a plain
// packet is delivered from the head slot, and a fragment group takes one pass to
// check the group and one pass to deliver it. the window memory needs no clearing
// pass after reset: per-slot valid bits live in flops.
module inorder_receive_window #(
   parameter int WINDOW   = 16,
   parameter int TAG_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_sequence_number,
   input  logic        req_hash_ok,
   input  logic        req_is_fragment,
   input  logic [15:0] req_fragment_index,
   input  logic [15:0] req_fragment_total,
   input  logic [15:0] req_payload_tag,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_result_kind,
   output logic [31:0] rsp_result_sequence,
   output logic [15:0] rsp_result_tag,
   output logic        rsp_part_of_group,
   output logic        rsp_group_end,
   output logic        rsp_is_last
);
   import iorw_pkg::*;

   localparam int IDXW = $clog2(WINDOW);
   localparam int CW   = $clog2(WINDOW + 1);
   localparam int TW   = (TAG_BITS < 16) ? TAG_BITS : 16;
   localparam int SW   = TW + 1 + IDXW + CW;

   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_CHECK   = 10'b0000000010,
      S_REL2    = 10'b0000000100,
      S_HEAD_RD = 10'b0000001000,
      S_HEAD    = 10'b0000010000,
      S_SCAN_RD = 10'b0000100000,
      S_SCAN    = 10'b0001000000,
      S_DEL_RD  = 10'b0010000000,
      S_DEL     = 10'b0100000000,
      S_FIN     = 10'b1000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [31:0]       exp_ff, exp_in;         // expected sequence number
   logic [IDXW-1:0]   hslot_ff, hslot_in;     // slot of the expected sequence
   logic [IDXW-1:0]   sslot_ff, sslot_in;     // slot walked by scan and deliver
   logic [CW-1:0]     i_ff, i_in;             // position within a group
   logic [CW-1:0]     cnt_ff, cnt_in;         // size of the head group
   logic [TW-1:0]     htag_ff, htag_in;       // tag of the head slot
   logic              comp_ff, comp_in;       // group complete so far
   logic [WINDOW-1:0] valid_ff, valid_in;

   // latched packet
   logic [31:0] seq_ff;
   logic        hash_ff, frag_ff;
   logic [15:0] fidx_ff, ftot_ff;
   logic [TW-1:0] tag_ff;

   logic          ram_we;
   logic [IDXW-1:0] ram_raddr;
   logic [SW-1:0] ram_wdata, ram_rdata;

   logic          push;
   result_type    res;
   logic          fin;

   // slot memory word fields
   logic [TW-1:0]   rd_tag;
   logic            rd_frag;
   logic [IDXW-1:0] rd_pos;
   logic [CW-1:0]   rd_cnt;

   // classification of the latched packet
   logic            bad, malformed, stale, beyond;
   logic [31:0]     diff;
   logic [IDXW:0]   slot_sum;
   logic [IDXW-1:0] slot_new;

   function automatic logic [IDXW-1:0] wrap_inc(input logic [IDXW-1:0] x);
      if (x == IDXW'(WINDOW - 1)) begin
         return '0;
      end
      return x + 1'b1;
   endfunction

   function automatic result_type mk_res(input kind_type k, input logic [31:0] s,
                                         input logic [15:0] t, input logic p,
                                         input logic g);
      result_type r;
      r.kind    = k;
      r.seq_num = s;
      r.tag     = t;
      r.part    = p;
      r.gend    = g;
      return r;
   endfunction

   assign {rd_tag, rd_frag, rd_pos, rd_cnt} = ram_rdata;

   assign bad       = !hash_ff;
   assign malformed = frag_ff && ((ftot_ff == 16'd0) || (ftot_ff > 16'(WINDOW)) ||
                                  (fidx_ff >= ftot_ff));
   assign stale     = seq_ff < exp_ff;
   assign diff      = seq_ff - exp_ff;
   assign beyond    = diff >= 32'(WINDOW);
   // window slot of the new packet, tracked from the head slot so any window size works
   assign slot_sum  = {1'b0, hslot_ff} + {1'b0, diff[IDXW-1:0]};
   assign slot_new  = (slot_sum >= (IDXW+1)'(WINDOW)) ?
                      IDXW'(slot_sum - (IDXW+1)'(WINDOW)) : slot_sum[IDXW-1:0];

   // non-fragments store position and count as zero
   assign ram_wdata = {tag_ff, frag_ff,
                       frag_ff ? fidx_ff[IDXW-1:0] : {IDXW{1'b0}},
                       frag_ff ? ftot_ff[CW-1:0]   : {CW{1'b0}}};

   always_comb begin
      state_in  = state_ff;
      exp_in    = exp_ff;
      hslot_in  = hslot_ff;
      sslot_in  = sslot_ff;
      i_in      = i_ff;
      cnt_in    = cnt_ff;
      htag_in   = htag_ff;
      comp_in   = comp_ff;
      valid_in  = valid_ff;
      push      = 1'b0;
      res       = mk_res(KIND_ACK, seq_ff, 16'd0, 1'b0, 1'b0);
      ram_we    = 1'b0;
      ram_raddr = hslot_ff;
      fin       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            push = 1'b1;
            if (bad || malformed || (!stale && beyond)) begin
               res      = mk_res(KIND_RELEASE, seq_ff, 16'(tag_ff), 1'b0, 1'b0);
               state_in = S_FIN;
            end else if (stale || valid_ff[slot_new]) begin
               // stale, duplicate or slot taken: ack, then release the buffer
               state_in = S_REL2;
            end else begin
               ram_we             = 1'b1;
               valid_in[slot_new] = 1'b1;
               state_in           = S_HEAD_RD;
            end
         end
         S_REL2: begin
            push     = 1'b1;
            res      = mk_res(KIND_RELEASE, seq_ff, 16'(tag_ff), 1'b0, 1'b0);
            state_in = S_FIN;
         end
         S_HEAD_RD: begin
            state_in = valid_ff[hslot_ff] ? S_HEAD : S_FIN;
         end
         S_HEAD: begin
            if (!rd_frag || (rd_pos != '0) || (rd_cnt == '0) ||
                (rd_cnt > CW'(WINDOW))) begin
               // plain packet goes out, orphan fragment is dropped
               push = 1'b1;
               res  = mk_res(rd_frag ? KIND_RELEASE : KIND_DELIVER, exp_ff,
                             16'(rd_tag), 1'b0, 1'b0);
               valid_in[hslot_ff] = 1'b0;
               exp_in   = exp_ff + 32'd1;
               hslot_in = wrap_inc(hslot_ff);
               state_in = S_HEAD_RD;
            end else begin
               cnt_in   = rd_cnt;
               htag_in  = rd_tag;
               i_in     = CW'(1);
               sslot_in = wrap_inc(hslot_ff);
               comp_in  = 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            ram_raddr = sslot_ff;
            if (i_ff == cnt_ff) begin
               if (comp_ff) begin
                  i_in     = '0;
                  sslot_in = hslot_ff;
                  state_in = S_DEL_RD;
               end else begin
                  state_in = S_FIN;
               end
            end else if (!valid_ff[sslot_ff]) begin
               comp_in  = 1'b0;
               i_in     = i_ff + 1'b1;
               sslot_in = wrap_inc(sslot_ff);
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!rd_frag || (CW'(rd_pos) != i_ff) || (rd_cnt != cnt_ff)) begin
               // a foreign packet in the group range orphans the head
               push = 1'b1;
               res  = mk_res(KIND_RELEASE, exp_ff, 16'(htag_ff), 1'b0, 1'b0);
               valid_in[hslot_ff] = 1'b0;
               exp_in   = exp_ff + 32'd1;
               hslot_in = wrap_inc(hslot_ff);
               state_in = S_HEAD_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               sslot_in = wrap_inc(sslot_ff);
               state_in = S_SCAN_RD;
            end
         end
         S_DEL_RD: begin
            ram_raddr = sslot_ff;
            state_in  = S_DEL;
         end
         S_DEL: begin
            push = 1'b1;
            res  = mk_res(KIND_DELIVER, exp_ff + 32'(i_ff), 16'(rd_tag), 1'b1,
                          (i_ff + CW'(1)) == cnt_ff);
            valid_in[sslot_ff] = 1'b0;
            if ((i_ff + CW'(1)) == cnt_ff) begin
               exp_in   = exp_ff + 32'(cnt_ff);
               hslot_in = wrap_inc(sslot_ff);
               state_in = S_HEAD_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               sslot_in = wrap_inc(sslot_ff);
               state_in = S_DEL_RD;
            end
         end
         S_FIN: begin
            fin      = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         exp_ff   <= '0;
         hslot_ff <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         exp_ff   <= exp_in;
         hslot_ff <= hslot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sslot_ff <= sslot_in;
      i_ff     <= i_in;
      cnt_ff   <= cnt_in;
      htag_ff  <= htag_in;
      comp_ff  <= comp_in;
      if (start && !busy) begin
         seq_ff  <= req_sequence_number;
         hash_ff <= req_hash_ok;
         frag_ff <= req_is_fragment;
         fidx_ff <= req_fragment_index;
         ftot_ff <= req_fragment_total;
         tag_ff  <= req_payload_tag[TW-1:0];
      end
   end

   assign busy = (state_ff != S_IDLE);

   iorw_ram #(
      .WIDTH(SW),
      .DEPTH(WINDOW)
   ) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_new),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   iorw_outq u_outq (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .res                 (res),
      .finish              (fin),
      .rsp_strobe          (rsp_strobe),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_result_sequence (rsp_result_sequence),
      .rsp_result_tag      (rsp_result_tag),
      .rsp_part_of_group   (rsp_part_of_group),
      .rsp_group_end       (rsp_group_end),
      .rsp_is_last         (rsp_is_last)
   );
endmodule

FILE: sv/iorw_chk.sv
module iorw_chk (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_result_kind,
   input logic        rsp_part_of_group,
   input logic        rsp_group_end,
   input logic        rsp_is_last
);
   import iorw_pkg::*;

   // a taken packet raises busy next cycle
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after take");

   // nothing follows the last word of a packet right away
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_is_last |=> !rsp_strobe)
      else $error("word right after last");

   // only the last word may show while idle
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_is_last |-> busy)
      else $error("non-last word while idle");

   // group marks only on deliveries
   a_group_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_part_of_group || rsp_group_end) |->
         rsp_result_kind == KIND_DELIVER)
      else $error("group mark on non-delivery");
endmodule

bind inorder_receive_window iorw_chk u_chk (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_result_kind   (rsp_result_kind),
   .rsp_part_of_group (rsp_part_of_group),
   .rsp_group_end     (rsp_group_end),
   .rsp_is_last       (rsp_is_last)
);
